/* hw/rtl/grid_node_boundary_response_core_assert.svh */
// assertion helpers for the boundary response core
`ifndef GRID_NODE_BOUNDARY_RESPONSE_CORE_ASSERT_SVH
`define GRID_NODE_BOUNDARY_RESPONSE_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define GNBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GNBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gnbr_pkg.sv */
`default_nettype none
package gnbr_pkg;

  localparam int Q_W     = 32;
  localparam int TAG_W   = 16;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 34;
  localparam int DIV_W   = 32;
  localparam int IN_W    = 272;
  localparam int OUT_W   = 80;
  localparam int CFG_A_W = 3;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  // pipeline stage numbers, counted from the input register
  localparam int ST_SQC    = 3;
  localparam int ST_TAN    = 6;
  localparam int ST_SQ_IN  = 7;
  localparam int ST_COL    = 10;
  localparam int ST_DV_IN  = ST_SQ_IN + SQ_STEPS + 3;
  localparam int ST_LAST   = ST_DV_IN + DIV_STEPS + 1;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_STICKY   = 2'd1,
    KIND_SEPARATE = 2'd2,
    KIND_INSIDE   = 2'd3
  } kind_t;

  typedef enum logic {
    OP_COLLIDE  = 1'b0,
    OP_FRICTION = 1'b1
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_KIND   = 3'd0,
    REG_NX     = 3'd1,
    REG_NY     = 3'd2,
    REG_AX     = 3'd3,
    REG_AY     = 3'd4,
    REG_STEP   = 3'd5,
    REG_RECIP  = 3'd6,
    REG_MU     = 3'd7
  } cfg_idx_t;

  // item data that rides alongside the arithmetic
  typedef struct packed {
    op_t                    op;
    logic [TAG_W-1:0]       tag;
    logic signed [Q_W-1:0]  vx;
    logic signed [Q_W-1:0]  vy;
    logic signed [Q_W-1:0]  cx;
    logic signed [Q_W-1:0]  cy;
    logic signed [Q_W-1:0]  fx;
    logic signed [Q_W-1:0]  fy;
    logic [RAD_W-1:0]       sqc;
    logic                   t_nz;
    logic                   sgn_x;
    logic                   sgn_y;
    logic [Q_W-1:0]         mtx;
    logic [Q_W-1:0]         mty;
    logic                   c_hit;
    logic signed [Q_W-1:0]  c_x;
    logic signed [Q_W-1:0]  c_y;
  } side_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] r;
    r = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/grid_node_boundary_response_core.sv */
`default_nettype none
// grid node boundary response, signed q16.16, one straight boundary line
// input channel in_*: one grid node item per handshake; in_tuser selects the
//   operation (collision test and response, or coulomb friction)
// result channel out_*: exactly one result item per input item, in order
// configuration: cfg_we / cfg_addr / cfg_wdata write one boundary register per
//   cycle; write only while no item is in flight
// throughput: one item per cycle while the receiver keeps up; the depth is set by the two
//   32-cell square root chains and the two 32-cell divider chains of the friction path
// the whole pipeline advances together whenever the result register is empty
//   or being taken; a stalled receiver holds every stage, in_tready drops
//   only while a finished result waits and out_tready is low
// reset (rst_n low, synchronous) empties the pipeline and loads the
//   boundary registers with kind separating, normal (0,1), anchor (0,0),
//   step 1.0, reciprocal 1.0, friction 0
`include "grid_node_boundary_response_core_assert.svh"
module grid_node_boundary_response_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // node_tag, pos_x, pos_y, vel_x, vel_y, col_x, col_y, damp_x, damp_y
  input  wire logic [gnbr_pkg::IN_W-1:0]     in_tdata,
  // operation
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // res_x, res_y, hit_tag
  output logic      [gnbr_pkg::OUT_W-1:0]    out_tdata,
  // collided
  output logic                               out_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [gnbr_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [gnbr_pkg::Q_W-1:0]      cfg_wdata
);
  import gnbr_pkg::*;

  // boundary registers
  kind_t                 kind_r;
  logic signed [Q_W-1:0] nx_r, ny_r, ax_r, ay_r;
  logic [Q_W-2:0]        step_r, recip_r, mu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_SEPARATE;
      nx_r    <= '0;
      ny_r    <= 32'sh00010000;
      ax_r    <= '0;
      ay_r    <= '0;
      step_r  <= 31'h00010000;
      recip_r <= 31'h00010000;
      mu_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_KIND:  kind_r  <= kind_t'(cfg_wdata[1:0]);
        REG_NX:    nx_r    <= cfg_wdata;
        REG_NY:    ny_r    <= cfg_wdata;
        REG_AX:    ax_r    <= cfg_wdata;
        REG_AY:    ay_r    <= cfg_wdata;
        REG_STEP:  step_r  <= cfg_wdata[Q_W-2:0];
        REG_RECIP: recip_r <= cfg_wdata[Q_W-2:0];
        REG_MU:    mu_r    <= cfg_wdata[Q_W-2:0];
        default:   kind_r  <= kind_r;
      endcase
    end
  end

  // input field split
  logic [TAG_W-1:0]      in_tag;
  logic signed [Q_W-1:0] in_px, in_py, in_vx, in_vy, in_cx, in_cy, in_fx, in_fy;
  assign in_tag = in_tdata[15:0];
  assign in_px  = in_tdata[47:16];
  assign in_py  = in_tdata[79:48];
  assign in_vx  = in_tdata[111:80];
  assign in_vy  = in_tdata[143:112];
  assign in_cx  = in_tdata[175:144];
  assign in_cy  = in_tdata[207:176];
  assign in_fx  = in_tdata[239:208];
  assign in_fy  = in_tdata[271:240];

  // global advance: every stage moves when the result register frees up
  logic              adv;
  logic [ST_LAST:1]  vld_r;
  assign adv       = !vld_r[ST_LAST] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_LAST-1:1], in_tvalid};
    end
  end

  // stage registers of the short arithmetic sections
  logic signed [Q_W:0]     s1_dx_r, s1_dy_r;
  logic signed [Q_W-1:0]   s1_ex_r, s1_ey_r;
  logic signed [2*Q_W:0]   s2_pd1_r, s2_pd2_r;
  logic signed [2*Q_W-1:0] s2_pv1_r, s2_pv2_r, s2_pn1_r, s2_pn2_r;
  logic [RAD_W-1:0]        s2_ec2x_r, s2_ec2y_r;
  logic signed [Q_W-1:0]   s3_d_r, s3_nv_r, s3_nd_r;
  logic signed [Q_W-1:0]   s4_d_r;
  logic signed [2*Q_W-1:0] s4_q_r, s4_pnx_r, s4_pny_r;
  logic signed [Q_W-1:0]   s5_d_r, s5_td_r, s5_tx_r, s5_ty_r;
  logic signed [Q_W-1:0]   s6_dc_r;
  logic                    s6_dneg_r;
  logic [RAD_W-1:0]        s6_tx2_r, s6_ty2_r;
  logic signed [2*Q_W-1:0] s7_sp_r;
  logic                    s7_dneg_r, s7_dcneg_r;
  logic [RAD_W-1:0]        s7_sqt_r;
  logic signed [Q_W-1:0]   s8_s_r;
  logic                    s8_dneg_r, s8_dcneg_r;
  logic signed [2*Q_W-1:0] s9_psx_r, s9_psy_r;
  logic                    s9_dneg_r, s9_dcneg_r;
  logic [2*Q_W-2:0]        s40_cap_r;
  logic [ROOT_W-1:0]       s40_nt_r;
  logic [ROOT_W-1:0]       s41_k_r, s41_nt_r;
  logic [RAD_W-1:0]        s42_numx_r, s42_numy_r;
  logic [ROOT_W-1:0]       s42_nt_r;
  logic signed [Q_W-1:0]   out_x_r, out_y_r;
  logic                    out_hit_r;
  logic [TAG_W-1:0]        out_tag_r;

  // side line carrying item data down the pipeline
  side_t side_r   [1:ST_LAST];
  side_t side_nxt [1:ST_LAST];

  logic signed [Q_W-1:0] col_x10, col_y10;
  logic                  hit10, zero10;

  // collision decision at the end of the short path
  always_comb begin
    col_x10 = sat32(66'(side_r[ST_COL-1].vx) - 66'(s9_psx_r >>> 16));
    col_y10 = sat32(66'(side_r[ST_COL-1].vy) - 66'(s9_psy_r >>> 16));
    zero10  = (kind_r == KIND_STICKY) && s9_dneg_r;
    hit10   = !zero10 && (((kind_r == KIND_SEPARATE) && s9_dcneg_r) ||
                          ((kind_r == KIND_INSIDE) && s9_dneg_r));
  end

  always_comb begin
    side_nxt[1]     = '0;
    side_nxt[1].op  = op_t'(in_tuser);
    side_nxt[1].tag = in_tag;
    side_nxt[1].vx  = in_vx;
    side_nxt[1].vy  = in_vy;
    side_nxt[1].cx  = in_cx;
    side_nxt[1].cy  = in_cy;
    side_nxt[1].fx  = in_fx;
    side_nxt[1].fy  = in_fy;
    for (int i = 2; i <= ST_LAST; i++) begin
      side_nxt[i] = side_r[i-1];
    end
    side_nxt[ST_SQC].sqc   = s2_ec2x_r + s2_ec2y_r;
    side_nxt[ST_TAN].t_nz  = (s5_tx_r != '0) || (s5_ty_r != '0);
    side_nxt[ST_TAN].sgn_x = s5_tx_r[Q_W-1];
    side_nxt[ST_TAN].sgn_y = s5_ty_r[Q_W-1];
    side_nxt[ST_TAN].mtx   = mag32(s5_tx_r);
    side_nxt[ST_TAN].mty   = mag32(s5_ty_r);
    if (zero10) begin
      side_nxt[ST_COL].c_x   = '0;
      side_nxt[ST_COL].c_y   = '0;
      side_nxt[ST_COL].c_hit = 1'b0;
    end else if (hit10) begin
      side_nxt[ST_COL].c_x   = col_x10;
      side_nxt[ST_COL].c_y   = col_y10;
      side_nxt[ST_COL].c_hit = 1'b1;
    end else begin
      side_nxt[ST_COL].c_x   = side_r[ST_COL-1].vx;
      side_nxt[ST_COL].c_y   = side_r[ST_COL-1].vy;
      side_nxt[ST_COL].c_hit = 1'b0;
    end
  end

  // square root chains: tangential norm and velocity change norm
  logic [RAD_W-1:0]  qt_v [0:SQ_STEPS];
  logic [REM_W-1:0]  qt_rem [0:SQ_STEPS];
  logic [ROOT_W-1:0] qt_root [0:SQ_STEPS];
  logic [RAD_W-1:0]  qc_v [0:SQ_STEPS];
  logic [REM_W-1:0]  qc_rem [0:SQ_STEPS];
  logic [ROOT_W-1:0] qc_root [0:SQ_STEPS];

  assign qt_v[0]    = s7_sqt_r;
  assign qt_rem[0]  = '0;
  assign qt_root[0] = '0;
  assign qc_v[0]    = side_r[ST_SQ_IN].sqc;
  assign qc_rem[0]  = '0;
  assign qc_root[0] = '0;

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
    gnbr_sqrt_cell u_sqt (
      .clk(clk), .en(adv),
      .v_i(qt_v[j-1]), .rem_i(qt_rem[j-1]), .root_i(qt_root[j-1]),
      .v_o(qt_v[j]), .rem_o(qt_rem[j]), .root_o(qt_root[j])
    );
    gnbr_sqrt_cell u_sqc (
      .clk(clk), .en(adv),
      .v_i(qc_v[j-1]), .rem_i(qc_rem[j-1]), .root_i(qc_root[j-1]),
      .v_o(qc_v[j]), .rem_o(qc_rem[j]), .root_o(qc_root[j])
    );
  end

  // divider chains: k*|t| / |t| per component
  logic [DIV_W-1:0] dx_n [0:DIV_STEPS];
  logic [DIV_W-1:0] dx_rem [0:DIV_STEPS];
  logic [DIV_W-1:0] dx_d [0:DIV_STEPS];
  logic [DIV_W-1:0] dx_q [0:DIV_STEPS];
  logic [DIV_W-1:0] dy_n [0:DIV_STEPS];
  logic [DIV_W-1:0] dy_rem [0:DIV_STEPS];
  logic [DIV_W-1:0] dy_d [0:DIV_STEPS];
  logic [DIV_W-1:0] dy_q [0:DIV_STEPS];

  assign dx_n[0]   = s42_numx_r[DIV_W-1:0];
  assign dx_rem[0] = s42_numx_r[RAD_W-1:DIV_W];
  assign dx_d[0]   = s42_nt_r;
  assign dx_q[0]   = '0;
  assign dy_n[0]   = s42_numy_r[DIV_W-1:0];
  assign dy_rem[0] = s42_numy_r[RAD_W-1:DIV_W];
  assign dy_d[0]   = s42_nt_r;
  assign dy_q[0]   = '0;

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    gnbr_div_cell u_dvx (
      .clk(clk), .en(adv),
      .n_i(dx_n[j-1]), .rem_i(dx_rem[j-1]), .d_i(dx_d[j-1]), .q_i(dx_q[j-1]),
      .n_o(dx_n[j]), .rem_o(dx_rem[j]), .d_o(dx_d[j]), .q_o(dx_q[j])
    );
    gnbr_div_cell u_dvy (
      .clk(clk), .en(adv),
      .n_i(dy_n[j-1]), .rem_i(dy_rem[j-1]), .d_i(dy_d[j-1]), .q_i(dy_q[j-1]),
      .n_o(dy_n[j]), .rem_o(dy_rem[j]), .d_o(dy_d[j]), .q_o(dy_q[j])
    );
  end

  // final stage
  side_t                 fin;
  logic signed [Q_W-1:0] fr_x_nxt, fr_y_nxt;
  logic signed [Q_W-1:0] res_x_nxt, res_y_nxt;
  logic                  hit_nxt;
  logic [TAG_W-1:0]      tag_nxt;

  always_comb begin
    fin = side_r[ST_LAST-1];
    if (fin.t_nz) begin
      fr_x_nxt = fin.sgn_x ? sat32(66'(fin.fx) + 66'($signed({1'b0, dx_q[DIV_STEPS]})))
                           : sat32(66'(fin.fx) - 66'($signed({1'b0, dx_q[DIV_STEPS]})));
      fr_y_nxt = fin.sgn_y ? sat32(66'(fin.fy) + 66'($signed({1'b0, dy_q[DIV_STEPS]})))
                           : sat32(66'(fin.fy) - 66'($signed({1'b0, dy_q[DIV_STEPS]})));
    end else begin
      fr_x_nxt = fin.fx;
      fr_y_nxt = fin.fy;
    end
    unique case (fin.op)
      OP_COLLIDE: begin
        res_x_nxt = fin.c_x;
        res_y_nxt = fin.c_y;
        hit_nxt   = fin.c_hit;
        tag_nxt   = fin.c_hit ? fin.tag : '0;
      end
      OP_FRICTION: begin
        res_x_nxt = fr_x_nxt;
        res_y_nxt = fr_y_nxt;
        hit_nxt   = 1'b0;
        tag_nxt   = '0;
      end
      default: begin
        res_x_nxt = fin.c_x;
        res_y_nxt = fin.c_y;
        hit_nxt   = 1'b0;
        tag_nxt   = '0;
      end
    endcase
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= ST_LAST; i++) begin
        side_r[i] <= side_nxt[i];
      end
      // offset from anchor and velocity change
      s1_dx_r <= 33'(in_px) - 33'(ax_r);
      s1_dy_r <= 33'(in_py) - 33'(ay_r);
      s1_ex_r <= sat32(66'(in_cx) - 66'(in_vx));
      s1_ey_r <= sat32(66'(in_cy) - 66'(in_vy));
      // dot product terms
      s2_pd1_r  <= 65'(nx_r) * 65'(s1_dx_r);
      s2_pd2_r  <= 65'(ny_r) * 65'(s1_dy_r);
      s2_pv1_r  <= 64'(nx_r) * 64'(side_r[1].vx);
      s2_pv2_r  <= 64'(ny_r) * 64'(side_r[1].vy);
      s2_pn1_r  <= 64'(nx_r) * 64'(side_r[1].fx);
      s2_pn2_r  <= 64'(ny_r) * 64'(side_r[1].fy);
      s2_ec2x_r <= 64'(mag32(s1_ex_r)) * 64'(mag32(s1_ex_r));
      s2_ec2y_r <= 64'(mag32(s1_ey_r)) * 64'(mag32(s1_ey_r));
      // signed distance, normal velocity, normal damp part
      s3_d_r  <= sat32(66'(s2_pd1_r >>> 16) + 66'(s2_pd2_r >>> 16));
      s3_nv_r <= sat32(66'(s2_pv1_r >>> 16) + 66'(s2_pv2_r >>> 16));
      s3_nd_r <= sat32(66'(s2_pn1_r >>> 16) + 66'(s2_pn2_r >>> 16));
      // travel over one step, normal projection
      s4_d_r   <= s3_d_r;
      s4_q_r   <= 64'($signed({1'b0, step_r})) * 64'(s3_nv_r);
      s4_pnx_r <= 64'(nx_r) * 64'(s3_nd_r);
      s4_pny_r <= 64'(ny_r) * 64'(s3_nd_r);
      // distance after the step, tangential velocity
      s5_d_r  <= s4_d_r;
      s5_td_r <= sat32(66'(s4_d_r) + 66'(s4_q_r >>> 16));
      s5_tx_r <= sat32(66'(side_r[4].cx) - 66'(s4_pnx_r >>> 16));
      s5_ty_r <= sat32(66'(side_r[4].cy) - 66'(s4_pny_r >>> 16));
      // penetration left after one step, min(d, 0) kept signed
      s6_dc_r   <= sat32(66'(s5_td_r) - (s5_d_r[Q_W-1] ? 66'(s5_d_r) : 66'sd0));
      s6_dneg_r <= s5_d_r[Q_W-1];
      s6_tx2_r  <= 64'(mag32(s5_tx_r)) * 64'(mag32(s5_tx_r));
      s6_ty2_r  <= 64'(mag32(s5_ty_r)) * 64'(mag32(s5_ty_r));
      // separation speed, radicand of the tangential norm
      s7_sp_r    <= 64'(s6_dc_r) * 64'($signed({1'b0, recip_r}));
      s7_dneg_r  <= s6_dneg_r;
      s7_dcneg_r <= s6_dc_r[Q_W-1];
      s7_sqt_r   <= s6_tx2_r + s6_ty2_r;
      s8_s_r     <= sat32(66'(s7_sp_r >>> 16));
      s8_dneg_r  <= s7_dneg_r;
      s8_dcneg_r <= s7_dcneg_r;
      s9_psx_r   <= 64'(s8_s_r) * 64'(nx_r);
      s9_psy_r   <= 64'(s8_s_r) * 64'(ny_r);
      s9_dneg_r  <= s8_dneg_r;
      s9_dcneg_r <= s8_dcneg_r;
      // friction cap and clamp
      s40_cap_r  <= 63'(mu_r) * 63'(qc_root[SQ_STEPS]);
      s40_nt_r   <= qt_root[SQ_STEPS];
      s41_k_r    <= (s40_cap_r[2*Q_W-2:16] < 47'(s40_nt_r)) ? s40_cap_r[47:16] : s40_nt_r;
      s41_nt_r   <= s40_nt_r;
      s42_numx_r <= 64'(s41_k_r) * 64'(side_r[ST_DV_IN-1].mtx);
      s42_numy_r <= 64'(s41_k_r) * 64'(side_r[ST_DV_IN-1].mty);
      s42_nt_r   <= s41_nt_r;
      // result register
      out_x_r   <= res_x_nxt;
      out_y_r   <= res_y_nxt;
      out_hit_r <= hit_nxt;
      out_tag_r <= tag_nxt;
    end
  end

  assign out_tvalid = vld_r[ST_LAST];
  assign out_tdata  = {out_tag_r, out_y_r, out_x_r};
  assign out_tuser  = out_hit_r;

  // a result with no recorded collision carries no tag
  `GNBR_ASSERT_NOW(a_tag_without_hit, out_tvalid && !out_tuser, out_tdata[79:64] == '0, "hit_tag set without collision")
  // a result only appears after the stage before it held an item
  `GNBR_ASSERT_NOW(a_out_from_pipe, $rose(out_tvalid), $past(vld_r[ST_LAST-1]), "result from empty stage")
  // every item taken in by a handshake reaches stage one
  `GNBR_ASSERT_NEXT(a_first_stage, in_tvalid && in_tready, vld_r[1], "accepted item lost at entry")

endmodule
`default_nettype wire

/* hw/rtl/gnbr_sqrt_cell.sv */
`default_nettype none
module gnbr_sqrt_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [gnbr_pkg::RAD_W-1:0]  v_i,
  input  wire logic [gnbr_pkg::REM_W-1:0]  rem_i,
  input  wire logic [gnbr_pkg::ROOT_W-1:0] root_i,
  output logic      [gnbr_pkg::RAD_W-1:0]  v_o,
  output logic      [gnbr_pkg::REM_W-1:0]  rem_o,
  output logic      [gnbr_pkg::ROOT_W-1:0] root_o
);
  import gnbr_pkg::*;

  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [RAD_W-1:0]  v_nxt;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0]  v_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // one root bit per cell: bring down two radicand bits, try root*4+1
  always_comb begin
    cur      = {rem_i, v_i[RAD_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (cur >= trial);
    rem_nxt  = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    v_nxt    = {v_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

/* hw/rtl/gnbr_div_cell.sv */
`default_nettype none
module gnbr_div_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [gnbr_pkg::DIV_W-1:0] n_i,
  input  wire logic [gnbr_pkg::DIV_W-1:0] rem_i,
  input  wire logic [gnbr_pkg::DIV_W-1:0] d_i,
  input  wire logic [gnbr_pkg::DIV_W-1:0] q_i,
  output logic      [gnbr_pkg::DIV_W-1:0] n_o,
  output logic      [gnbr_pkg::DIV_W-1:0] rem_o,
  output logic      [gnbr_pkg::DIV_W-1:0] d_o,
  output logic      [gnbr_pkg::DIV_W-1:0] q_o
);
  import gnbr_pkg::*;

  logic [DIV_W:0]   cur;
  logic             ge;
  logic [DIV_W-1:0] n_nxt;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W-1:0] q_nxt;
  logic [DIV_W-1:0] n_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] d_r;
  logic [DIV_W-1:0] q_r;

  // restoring step, remainder stays below the divisor when it enters below it
  always_comb begin
    cur     = {rem_i, n_i[DIV_W-1]};
    ge      = (cur >= {1'b0, d_i});
    rem_nxt = ge ? DIV_W'(cur - {1'b0, d_i}) : cur[DIV_W-1:0];
    q_nxt   = {q_i[DIV_W-2:0], ge};
    n_nxt   = {n_i[DIV_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
      d_r   <= d_i;
      q_r   <= q_nxt;
    end
  end

  assign n_o   = n_r;
  assign rem_o = rem_r;
  assign d_o   = d_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

/* verif/grid_node_boundary_response_checker.sv */
`timescale 1ns / 100ps
module grid_node_boundary_response_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [gnbr_pkg::IN_W-1:0]     in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [gnbr_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [gnbr_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [gnbr_pkg::Q_W-1:0]      cfg_wdata,
  output int                            mismatches,
  output int                            waiting
);
  import gnbr_pkg::*;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               hit;
    logic [15:0]        tag;
  } velocity_t;

  // boundary registers as the block should hold them
  logic [1:0]  b_kind;
  longint      b_nx, b_ny, b_ax, b_ay, b_dt, b_rdt, b_mu;
  velocity_t   expected_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product floored to q16.16
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned vec_len(longint a, longint b);
    return root_floor(absval(a) * absval(a) + absval(b) * absval(b));
  endfunction

  // k * comp / |t|, truncated toward zero
  function automatic longint share(longint unsigned k, longint comp, longint unsigned nt);
    longint unsigned q;
    q = (k * absval(comp)) / nt;
    return comp < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic velocity_t respond(logic [IN_W-1:0] d, logic op);
    velocity_t r;
    longint px, py, vx, vy, cx, cy, fx, fy, gap, nv, td, dc, s, nd, tx, ty;
    longint unsigned nt, nc, cap, k;
    px = longint'($signed(d[47:16]));   py = longint'($signed(d[79:48]));
    vx = longint'($signed(d[111:80]));  vy = longint'($signed(d[143:112]));
    cx = longint'($signed(d[175:144])); cy = longint'($signed(d[207:176]));
    fx = longint'($signed(d[239:208])); fy = longint'($signed(d[271:240]));
    r = '0;
    if (op_t'(op) == OP_COLLIDE) begin
      gap = clamp32(qmul(b_nx, px - b_ax) + qmul(b_ny, py - b_ay));
      nv = clamp32(qmul(b_nx, vx) + qmul(b_ny, vy));
      td = clamp32(gap + qmul(b_dt, nv));
      dc = clamp32(td - (gap < 0 ? gap : 0));
      r.rx = vx[31:0];
      r.ry = vy[31:0];
      if (kind_t'(b_kind) == KIND_STICKY && gap < 0) begin
        r.rx = '0;
        r.ry = '0;
      end else if ((kind_t'(b_kind) == KIND_SEPARATE && dc < 0) ||
                   (kind_t'(b_kind) == KIND_INSIDE && gap < 0)) begin
        s = clamp32(qmul(dc, b_rdt));
        r.rx = 32'(clamp32(vx - qmul(s, b_nx)));
        r.ry = 32'(clamp32(vy - qmul(s, b_ny)));
        r.hit = 1'b1;
        r.tag = d[15:0];
      end
    end else begin
      nd = clamp32(qmul(b_nx, fx) + qmul(b_ny, fy));
      tx = clamp32(cx - qmul(b_nx, nd));
      ty = clamp32(cy - qmul(b_ny, nd));
      r.rx = fx[31:0];
      r.ry = fy[31:0];
      // no tangential part means nothing to damp
      if (tx != 0 || ty != 0) begin
        nt = vec_len(tx, ty);
        nc = vec_len(clamp32(cx - vx), clamp32(cy - vy));
        cap = (longint'(b_mu) * nc) >> 16;
        k = cap < nt ? cap : nt;
        r.rx = 32'(clamp32(fx - share(k, tx, nt)));
        r.ry = 32'(clamp32(fy - share(k, ty, nt)));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    velocity_t want, got;
    if (!rst_n) begin
      b_kind <= KIND_SEPARATE;
      b_nx <= 0; b_ny <= 65536; b_ax <= 0; b_ay <= 0;
      b_dt <= 65536; b_rdt <= 65536; b_mu <= 0;
      expected_q.delete();
      mismatches <= 0;
      waiting <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_KIND:  b_kind <= cfg_wdata[1:0];
          REG_NX:    b_nx <= longint'($signed(cfg_wdata));
          REG_NY:    b_ny <= longint'($signed(cfg_wdata));
          REG_AX:    b_ax <= longint'($signed(cfg_wdata));
          REG_AY:    b_ay <= longint'($signed(cfg_wdata));
          REG_STEP:  b_dt <= longint'(cfg_wdata[30:0]);
          REG_RECIP: b_rdt <= longint'(cfg_wdata[30:0]);
          REG_MU:    b_mu <= longint'(cfg_wdata[30:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(), respond(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got.rx = out_tdata[31:0];
        got.ry = out_tdata[63:32];
        got.tag = out_tdata[79:64];
        got.hit = out_tuser;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result item %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display("mismatch: res_x %h/%h res_y %h/%h collided %b/%b tag %h/%h (exp/act)",
                       want.rx, got.rx, want.ry, got.ry, want.hit, got.hit,
                       want.tag, got.tag);
            mismatches <= mismatches + 1;
          end
        end
      end
      waiting <= expected_q.size();
    end
  end

endmodule

/* verif/grid_node_boundary_response_core_tb.sv */
`timescale 1ns / 100ps
module grid_node_boundary_response_core_tb;
  import gnbr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // node_tag, pos_x, pos_y, vel_x, vel_y, col_x, col_y, damp_x, damp_y
  logic [IN_W-1:0]   in_tdata = '0;
  // operation
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // res_x, res_y, hit_tag
  logic [OUT_W-1:0]  out_tdata;
  // collided
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [Q_W-1:0]    cfg_wdata = '0;

  int mismatches, waiting;
  int idle_pct = 0;     // sender gap chance, percent
  int stall_pct = 0;    // receiver stall chance, percent
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_node_boundary_response_core dut (.*);

  grid_node_boundary_response_checker chk (.*);

  // receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one register write per cycle; cfg_we is lowered by the caller
  task automatic put_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_boundary(logic [1:0] kind, logic [31:0] nx, logic [31:0] ny,
                               logic [31:0] ax, logic [31:0] ay, logic [31:0] dt,
                               logic [31:0] rdt, logic [31:0] mu);
    put_reg(REG_KIND, {30'd0, kind});
    put_reg(REG_NX, nx);
    put_reg(REG_NY, ny);
    put_reg(REG_AX, ax);
    put_reg(REG_AY, ay);
    put_reg(REG_STEP, dt);
    put_reg(REG_RECIP, rdt);
    put_reg(REG_MU, mu);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let everything in flight come out before touching the registers
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0 || out_tvalid) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_node(op_t op, logic [15:0] tag, logic [31:0] px, logic [31:0] py,
                           logic [31:0] vx, logic [31:0] vy, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] fx, logic [31:0] fy);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {fy, fx, cy, cx, vy, vx, py, px, tag};
    // in_tready is settled by the falling edge and holds until the next rise
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
  endtask

  // mostly modest magnitudes so that nodes land near the wall, sometimes full range
  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2:    return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  function automatic logic [31:0] unit_comp();
    case ($urandom_range(7))
      0: return 32'd65536;
      1: return -32'sd65536;
      2: return 32'd46341;
      3: return -32'sd46341;
      4: return 32'd0;
      5: return $urandom;
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] pos31();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'h7fffffff;
      2: return 32'($urandom) & 32'h7fffffff;
      default: return $urandom_range(32'h30000, 32'h800);
    endcase
  endfunction

  task automatic random_node;
    send_node(op_t'($urandom_range(1)), 16'($urandom), coord(), coord(), coord(), coord(),
              coord(), coord(), coord(), coord());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings: wall y = 0, normal up
    send_node(OP_COLLIDE, 16'h1234, 32'd0, -32'sd65536, 32'd0, -32'sd65536,
              0, 0, 0, 0);                                       // inside, moving in
    send_node(OP_COLLIDE, 16'hffff, 32'd0, 32'd65536, 32'd0, -32'sd131072,
              0, 0, 0, 0);                                       // crosses in one step
    send_node(OP_COLLIDE, 16'h0000, 32'd0, 32'd65536, 32'd0, 32'd65536,
              0, 0, 0, 0);                                       // moving away
    send_node(OP_COLLIDE, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 0, 0, 0, 0);                         // extremes, saturation
    send_node(OP_COLLIDE, 16'h8001, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 0, 0, 0, 0);
    send_node(OP_FRICTION, 16'hffff, 0, 0, 32'd0, 32'd0, 32'd65536, 32'd0,
              32'd65536, 32'd0);                                 // friction zero mu
    send_node(OP_FRICTION, 16'h5555, 0, 0, 0, 0, 0, 0, 0, 32'd65536); // damp along the normal, zero mu
    drain();

    load_boundary(KIND_STICKY, 0, 32'd65536, 0, 0, 32'd65536, 32'd65536, 32'd32768);
    send_node(OP_COLLIDE, 16'h00aa, 0, -32'sd1, 32'd100, 32'd200, 0, 0, 0, 0); // sticky inside
    send_node(OP_COLLIDE, 16'h00bb, 0, 32'd1, 32'd100, -32'sd200, 0, 0, 0, 0); // sticky outside
    send_node(OP_FRICTION, 16'h1, 0, 0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd65536, 0);
    send_node(OP_FRICTION, 16'h2, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_node(OP_FRICTION, 16'h3, 0, 0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 0);
    drain();

    load_boundary(KIND_INSIDE, 32'd46341, 32'd46341, 32'd65536, 32'd65536,
                  32'h7fffffff, 32'd1, 32'h7fffffff);
    send_node(OP_COLLIDE, 16'hcafe, 0, 0, 32'd65536, 32'd65536, 0, 0, 0, 0);
    send_node(OP_COLLIDE, 16'hbeef, 32'd200000, 32'd200000, -32'sd65536, 0, 0, 0, 0, 0);
    send_node(OP_FRICTION, 16'h4, 0, 0, -32'sd65536, 32'd3, 32'd65536, -32'sd7,
              32'd99, -32'sd99);
    drain();

    load_boundary(KIND_NONE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'd1, 32'h7fffffff, 32'd0);
    send_node(OP_COLLIDE, 16'h7777, 32'h7fffffff, 32'h80000000, 32'd5, -32'sd5, 0, 0, 0, 0);
    send_node(OP_FRICTION, 16'h8888, 0, 0, 32'h7fffffff, 0, 32'h80000000, 0, 32'd1, 32'd1);
    drain();

    // random phases: each gets a new boundary and an idling pattern chosen by ph % 5
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        3: begin idle_pct = 33; stall_pct = 33; end
        default: begin idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
      endcase
      load_boundary(ph == 9 ? 2'd0 : 2'($urandom_range(3, 1)), unit_comp(), unit_comp(),
                    coord(), coord(), pos31(), pos31(),
                    $urandom_range(3) == 0 ? (32'($urandom) & 32'h7fffffff)
                                           : $urandom_range(32'h20000));
      repeat (125) random_node();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/gnbr_pkg.sv
hw/rtl/gnbr_sqrt_cell.sv
hw/rtl/gnbr_div_cell.sv
hw/rtl/grid_node_boundary_response_core.sv
verif/grid_node_boundary_response_checker.sv
verif/grid_node_boundary_response_core_tb.sv
